/* rtl/dtd_pkg.sv */
package dtd_pkg;

  localparam int TAG_BYTES_DEF = 4;
  localparam int LEN_BYTES_DEF = 4;

  localparam logic [1:0] KIND_HDR     = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_ERR     = 2'd2;

  localparam logic ECODE_MALFORMED = 1'b0;
  localparam logic ECODE_HIGH_TAG  = 1'b1;

  localparam logic [7:0] OCT_MSB      = 8'h80;
  localparam logic [4:0] TAG_HIGH_ID  = 5'h1f;
  localparam int         LEN_LONG_MIN = 128;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tag;
    logic [31:0] content_length;
    logic [3:0]  header_length;
    logic [7:0]  content_byte;
    logic        error_code;
    logic        stream_done;
  } res_t;

endpackage

/* rtl/dtd_if.sv */
interface dtd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_stream;
  logic       last_byte;

  modport source(output valid, data_byte, start_of_stream, last_byte, input ready);
  modport sink(input valid, data_byte, start_of_stream, last_byte, output ready);
endinterface

interface dtd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] tag;
  logic [31:0] content_length;
  logic [3:0]  header_length;
  logic [7:0]  content_byte;
  logic        error_code;
  logic        stream_done;

  modport source(output valid, kind, tag, content_length, header_length, content_byte,
                 error_code, stream_done, input ready);
  modport sink(input valid, kind, tag, content_length, header_length, content_byte,
               error_code, stream_done, output ready);
endinterface

/* rtl/dtd_core.sv */
module dtd_core #(
  parameter int TAG_BYTES = dtd_pkg::TAG_BYTES_DEF,
  parameter int LEN_BYTES = dtd_pkg::LEN_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic            cfg_wdata,
  input  logic            accept,
  input  logic [7:0]      data_byte,
  input  logic            start_of_stream,
  input  logic            last_byte,
  output logic            push,
  output dtd_pkg::res_t   res
);

  localparam int TNW = 8 * TAG_BYTES - 8;
  localparam int FTW = 8 * TAG_BYTES;
  localparam int LVW = 8 * LEN_BYTES;

  localparam logic [2:0] PH_TAG_FIRST = 3'd0;
  localparam logic [2:0] PH_TAG_HIGH  = 3'd1;
  localparam logic [2:0] PH_LEN_FIRST = 3'd2;
  localparam logic [2:0] PH_LEN_MORE  = 3'd3;
  localparam logic [2:0] PH_CONTENT   = 3'd4;

  logic           allow_r;
  logic [2:0]     phase_r, phase_cur, phase_nxt;
  logic [7:0]     first_r, first_cur, first_nxt;
  logic [TNW-1:0] tn_r, tn_cur, tn_nxt, tn_new;
  logic [3:0]     oi_r, oi_cur, oi_nxt;
  logic [3:0]     lol_r, lol_cur, lol_nxt, lol_dec;
  logic [LVW-1:0] lv_r, lv_cur, lv_nxt, lv_sh, hd_lv;
  logic [LVW-1:0] crem_r, crem_cur, crem_nxt, crem_dec;
  logic           err_r, err_cur, err_nxt;
  logic [LVW+7:0] lv_wide;
  logic [FTW-1:0] ftag;
  logic [63:0]    ftag64, lv64;
  logic           hdr, fail, fcode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_r <= 1'b1;
    end else if (cfg_we) begin
      allow_r <= cfg_wdata;
    end
  end

  // start of stream clears the parser before the byte is used
  always_comb begin
    if (start_of_stream) begin
      phase_cur = PH_TAG_FIRST;
      first_cur = '0;
      tn_cur    = '0;
      oi_cur    = '0;
      lol_cur   = '0;
      lv_cur    = '0;
      crem_cur  = '0;
      err_cur   = 1'b0;
    end else begin
      phase_cur = phase_r;
      first_cur = first_r;
      tn_cur    = tn_r;
      oi_cur    = oi_r;
      lol_cur   = lol_r;
      lv_cur    = lv_r;
      crem_cur  = crem_r;
      err_cur   = err_r;
    end
  end

  assign tn_new   = {tn_cur[TNW-8:0], data_byte[6:0]};
  assign lv_wide  = {lv_cur, data_byte};
  assign lv_sh    = lv_wide[LVW-1:0];
  assign crem_dec = (crem_cur != '0) ? (crem_cur - LVW'(1)) : crem_cur;
  assign lol_dec  = lol_cur - 4'd1;
  assign ftag     = (first_cur[4:0] != dtd_pkg::TAG_HIGH_ID) ? FTW'(first_cur)
                                                             : {first_cur[7:5], 5'b0, tn_cur};
  assign ftag64   = 64'(ftag);
  assign lv64     = 64'(hd_lv);

  always_comb begin
    phase_nxt = phase_cur;
    first_nxt = first_cur;
    tn_nxt    = tn_cur;
    oi_nxt    = oi_cur;
    lol_nxt   = lol_cur;
    lv_nxt    = lv_cur;
    crem_nxt  = crem_cur;
    err_nxt   = err_cur;
    hdr       = 1'b0;
    hd_lv     = lv_sh;
    fail      = 1'b0;
    fcode     = dtd_pkg::ECODE_MALFORMED;
    push      = 1'b0;
    res       = '0;

    if (accept && !err_cur) begin
      case (phase_cur)
        PH_TAG_FIRST: begin
          first_nxt = data_byte;
          tn_nxt    = '0;
          oi_nxt    = 4'd1;
          lv_nxt    = '0;
          if (data_byte[4:0] != dtd_pkg::TAG_HIGH_ID) begin
            if (last_byte) fail = 1'b1;
            else phase_nxt = PH_LEN_FIRST;
          end else if (!allow_r) begin
            fail  = 1'b1;
            fcode = dtd_pkg::ECODE_HIGH_TAG;
          end else if (last_byte) begin
            fail = 1'b1;
          end else begin
            phase_nxt = PH_TAG_HIGH;
          end
        end
        PH_TAG_HIGH: begin
          if (oi_cur == 4'd1 && data_byte == dtd_pkg::OCT_MSB) begin
            fail = 1'b1;
          end else if (tn_cur[TNW-1 -: 7] != '0) begin
            // no room left for another 7-bit group
            fail = 1'b1;
          end else begin
            tn_nxt = tn_new;
            oi_nxt = oi_cur + 4'd1;
            if (!data_byte[7]) begin
              if (tn_new < TNW'(dtd_pkg::TAG_HIGH_ID)) fail = 1'b1;
              else if (last_byte) fail = 1'b1;
              else phase_nxt = PH_LEN_FIRST;
            end else if (last_byte) begin
              fail = 1'b1;
            end
          end
        end
        PH_LEN_FIRST: begin
          oi_nxt = oi_cur + 4'd1;
          if (!data_byte[7]) begin
            hdr   = 1'b1;
            hd_lv = LVW'(data_byte);
          end else begin
            lol_nxt = data_byte[3:0];
            if (data_byte[6:0] == 7'd0 || data_byte[6:0] > 7'(LEN_BYTES)) begin
              fail = 1'b1;
            end else if (last_byte) begin
              fail = 1'b1;
            end else begin
              lv_nxt    = '0;
              phase_nxt = PH_LEN_MORE;
            end
          end
        end
        PH_LEN_MORE: begin
          if (lv_cur == '0 && data_byte == 8'd0) begin
            fail = 1'b1;
          end else begin
            oi_nxt  = oi_cur + 4'd1;
            lv_nxt  = lv_sh;
            lol_nxt = lol_dec;
            if (lol_dec == 4'd0) begin
              if (lv_sh < LVW'(dtd_pkg::LEN_LONG_MIN)) fail = 1'b1;
              else hdr = 1'b1;
            end else if (last_byte) begin
              fail = 1'b1;
            end
          end
        end
        PH_CONTENT: begin
          crem_nxt = crem_dec;
          if (last_byte && crem_dec != '0) begin
            fail = 1'b1;
          end else begin
            if (crem_dec == '0) phase_nxt = PH_TAG_FIRST;
            push             = 1'b1;
            res.kind         = dtd_pkg::KIND_CONTENT;
            res.content_byte = data_byte;
            res.stream_done  = last_byte && (crem_dec == '0);
          end
        end
        default: fail = 1'b1;
      endcase

      if (hdr) begin
        lv_nxt = hd_lv;
        if (last_byte && hd_lv != '0) begin
          fail = 1'b1;
        end else begin
          crem_nxt           = hd_lv;
          phase_nxt          = (hd_lv == '0) ? PH_TAG_FIRST : PH_CONTENT;
          push               = 1'b1;
          res.kind           = dtd_pkg::KIND_HDR;
          res.tag            = ftag64[31:0];
          res.content_length = lv64[31:0];
          res.header_length  = oi_nxt;
          res.stream_done    = last_byte && (hd_lv == '0);
        end
      end

      if (fail) begin
        err_nxt        = 1'b1;
        phase_nxt      = PH_TAG_FIRST;
        push           = 1'b1;
        res            = '0;
        res.kind       = dtd_pkg::KIND_ERR;
        res.error_code = fcode;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG_FIRST;
      first_r <= '0;
      tn_r    <= '0;
      oi_r    <= '0;
      lol_r   <= '0;
      lv_r    <= '0;
      crem_r  <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      tn_r    <= tn_nxt;
      oi_r    <= oi_nxt;
      lol_r   <= lol_nxt;
      lv_r    <= lv_nxt;
      crem_r  <= crem_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

/* rtl/dtd_skid.sv */
module dtd_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dtd_pkg::res_t push_data,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output dtd_pkg::res_t out_data
);

  logic          ov_r, ov_nxt;
  logic          sv_r, sv_nxt;
  dtd_pkg::res_t od_r, od_nxt;
  dtd_pkg::res_t sd_r, sd_nxt;

  assign in_ready  = !sv_r;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    ov_nxt = ov_r;
    sv_nxt = sv_r;
    od_nxt = od_r;
    sd_nxt = sd_r;
    if (!ov_r || out_ready) begin
      // output slot frees: drain the skid word first
      if (sv_r) begin
        ov_nxt = 1'b1;
        od_nxt = sd_r;
        sv_nxt = 1'b0;
      end else begin
        ov_nxt = push;
        od_nxt = push_data;
      end
    end else if (push) begin
      sv_nxt = 1'b1;
      sd_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    sd_r <= sd_nxt;
  end

endmodule

/* rtl/der_tlv_stream_decoder.sv */
// Results: each one is registered into the output slot, or into the skid slot if the output
// is stalled. Throughput: one byte per cycle while in_ready is high; the whole decode step
// sits between the parser state registers and a two-entry output register, so an output stall
// reaches in_ready in the next cycle. Reset: synchronous, active low; clears the parser, the
// error latch and the output stage, and sets the high-tag enable allow_r to 1.
module der_tlv_stream_decoder #(
  parameter int TAG_BYTES = dtd_pkg::TAG_BYTES_DEF,
  parameter int LEN_BYTES = dtd_pkg::LEN_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dtd_in_if.sink     in_chan,
  dtd_out_if.source  out_chan,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  logic          accept;
  logic          push;
  logic          in_ready;
  dtd_pkg::res_t push_data;
  dtd_pkg::res_t out_data;

  assign in_chan.ready = in_ready;
  assign accept        = in_chan.valid && in_ready;

  dtd_core #(
    .TAG_BYTES(TAG_BYTES),
    .LEN_BYTES(LEN_BYTES)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .accept         (accept),
    .data_byte      (in_chan.data_byte),
    .start_of_stream(in_chan.start_of_stream),
    .last_byte      (in_chan.last_byte),
    .push           (push),
    .res            (push_data)
  );

  dtd_skid u_skid (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .in_ready (in_ready),
    .out_valid(out_chan.valid),
    .out_ready(out_chan.ready),
    .out_data (out_data)
  );

  assign out_chan.kind           = out_data.kind;
  assign out_chan.tag            = out_data.tag;
  assign out_chan.content_length = out_data.content_length;
  assign out_chan.header_length  = out_data.header_length;
  assign out_chan.content_byte   = out_data.content_byte;
  assign out_chan.error_code     = out_data.error_code;
  assign out_chan.stream_done    = out_data.stream_done;

endmodule

/* rtl/dtd_checker.sv */
module dtd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [31:0] out_tag,
  input logic [3:0]  out_header_length,
  input logic        out_stream_done
);

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_tag))
    else $error("stalled output word changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled while output is empty");

  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == dtd_pkg::KIND_ERR |-> !out_stream_done && out_tag == 32'd0)
    else $error("error word carries header fields or end of stream");

  a_header_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == dtd_pkg::KIND_HDR |-> out_header_length >= 4'd2)
    else $error("header word with short header length");

endmodule

bind der_tlv_stream_decoder dtd_checker u_dtd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_kind         (out_chan.kind),
  .out_tag          (out_chan.tag),
  .out_header_length(out_chan.header_length),
  .out_stream_done  (out_chan.stream_done)
);

/* dv/der_tlv_stream_decoder_test.sv */
module der_tlv_stream_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAG_BYTES = dtd_pkg::TAG_BYTES_DEF;
  localparam int LEN_BYTES = dtd_pkg::LEN_BYTES_DEF;
  // tag number must fit this before another 7 bit shift
  localparam longint unsigned TAG_ROOM = (64'd1 << (8 * TAG_BYTES - 15)) - 1;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [2:0] {SEEK_TAG, TAG_MORE, LEN_HEAD, LEN_MORE, BODY} tlv_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
  } octet_t;

  class tlv_scoreboard;
    dtd_pkg::res_t due_results[$];
    bit            allow_high = 1'b1;
    tlv_phase_t    phase;
    logic [7:0]    id_octet;
    logic [63:0]   tag_num;
    logic [63:0]   len_val;
    logic [63:0]   body_left;
    int            hdr_octets;
    int            len_left;
    bit            dead;
    int            mismatches;
    int            headers;
    int            bodies;
    int            faults;

    function new();
      restart();
    endfunction

    function void restart();
      phase = SEEK_TAG;
      id_octet = '0;
      tag_num = '0;
      hdr_octets = 0;
      len_left = 0;
      len_val = '0;
      body_left = '0;
      dead = 1'b0;
    endfunction

    function void reject(logic code);
      dtd_pkg::res_t r;
      r = '0;
      r.kind = dtd_pkg::KIND_ERR;
      r.error_code = code;
      dead = 1'b1;
      phase = SEEK_TAG;
      due_results.push_back(r);
    endfunction

    function void close_header(bit last);
      dtd_pkg::res_t r;
      if (last && len_val != 0) begin
        reject(dtd_pkg::ECODE_MALFORMED);
        return;
      end
      body_left = len_val;
      phase = (len_val == 0) ? SEEK_TAG : BODY;
      r = '0;
      r.kind = dtd_pkg::KIND_HDR;
      if (id_octet[4:0] != dtd_pkg::TAG_HIGH_ID) begin
        r.tag = 32'(id_octet);
      end else begin
        r.tag = 32'((64'(id_octet & 8'he0) << ((TAG_BYTES - 1) * 8)) | tag_num);
      end
      r.content_length = len_val[31:0];
      r.header_length = 4'(hdr_octets);
      r.stream_done = last && len_val == 0;
      due_results.push_back(r);
    endfunction

    function void decode_octet(octet_t o);
      dtd_pkg::res_t r;
      if (o.start) restart();
      if (dead) return;
      case (phase)
        SEEK_TAG: begin
          id_octet = o.data;
          tag_num = '0;
          hdr_octets = 1;
          len_val = '0;
          if (o.data[4:0] != dtd_pkg::TAG_HIGH_ID) begin
            if (o.last) reject(dtd_pkg::ECODE_MALFORMED);
            else phase = LEN_HEAD;
          end else if (!allow_high) begin
            reject(dtd_pkg::ECODE_HIGH_TAG);
          end else if (o.last) begin
            reject(dtd_pkg::ECODE_MALFORMED);
          end else begin
            phase = TAG_MORE;
          end
        end
        TAG_MORE: begin
          if (hdr_octets == 1 && o.data == dtd_pkg::OCT_MSB) begin
            reject(dtd_pkg::ECODE_MALFORMED);
          end else if (tag_num > TAG_ROOM) begin
            reject(dtd_pkg::ECODE_MALFORMED);
          end else begin
            tag_num = (tag_num << 7) | 64'(o.data[6:0]);
            hdr_octets++;
            if (!o.data[7]) begin
              if (tag_num < 64'(dtd_pkg::TAG_HIGH_ID) || o.last) begin
                reject(dtd_pkg::ECODE_MALFORMED);
              end else begin
                phase = LEN_HEAD;
              end
            end else if (o.last) begin
              reject(dtd_pkg::ECODE_MALFORMED);
            end
          end
        end
        LEN_HEAD: begin
          hdr_octets++;
          if (!o.data[7]) begin
            len_val = 64'(o.data);
            close_header(o.last);
          end else begin
            len_left = int'(o.data[6:0]);
            if (len_left == 0 || len_left > LEN_BYTES || o.last) begin
              reject(dtd_pkg::ECODE_MALFORMED);
            end else begin
              len_val = '0;
              phase = LEN_MORE;
            end
          end
        end
        LEN_MORE: begin
          if (len_val == 0 && o.data == 8'h00) begin
            reject(dtd_pkg::ECODE_MALFORMED);
          end else begin
            hdr_octets++;
            len_val = (len_val << 8) | 64'(o.data);
            len_left--;
            if (len_left == 0) begin
              if (len_val < dtd_pkg::LEN_LONG_MIN) reject(dtd_pkg::ECODE_MALFORMED);
              else close_header(o.last);
            end else if (o.last) begin
              reject(dtd_pkg::ECODE_MALFORMED);
            end
          end
        end
        BODY: begin
          if (body_left != 0) body_left--;
          if (o.last && body_left != 0) begin
            reject(dtd_pkg::ECODE_MALFORMED);
          end else begin
            if (body_left == 0) phase = SEEK_TAG;
            r = '0;
            r.kind = dtd_pkg::KIND_CONTENT;
            r.content_byte = o.data;
            r.stream_done = o.last;
            due_results.push_back(r);
          end
        end
        default: reject(dtd_pkg::ECODE_MALFORMED);
      endcase
    endfunction

    function void field_check(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void match_result(dtd_pkg::res_t got);
      dtd_pkg::res_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing due: kind %0d tag 0x%0h", got.kind, got.tag);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      field_check("kind", 32'(want.kind), 32'(got.kind));
      field_check("tag", want.tag, got.tag);
      field_check("content_length", want.content_length, got.content_length);
      field_check("header_length", 32'(want.header_length), 32'(got.header_length));
      field_check("content_byte", 32'(want.content_byte), 32'(got.content_byte));
      field_check("error_code", 32'(want.error_code), 32'(got.error_code));
      field_check("stream_done", 32'(want.stream_done), 32'(got.stream_done));
      case (want.kind)
        dtd_pkg::KIND_HDR:     headers++;
        dtd_pkg::KIND_CONTENT: bodies++;
        default:               faults++;
      endcase
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  dtd_in_if  in_ch();
  dtd_out_if out_ch();

  der_tlv_stream_decoder uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  tlv_scoreboard tlv_sb = new();
  octet_t        stream_q[$];
  int            idle_pct = 0;
  bit            quiet = 1'b0;
  int            hold_requests = 0;
  int            octets_fed = 0;
  int            settings_used = 0;
  int            cycle_count = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      tlv_sb.decode_octet(octet_t'({in_ch.data_byte, in_ch.start_of_stream, in_ch.last_byte}));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tlv_sb.match_result(dtd_pkg::res_t'({out_ch.kind, out_ch.tag, out_ch.content_length,
                                           out_ch.header_length, out_ch.content_byte,
                                           out_ch.error_code, out_ch.stream_done}));
    end
  end

  // result side: short random stalls, plus one long hold-off on request
  initial begin : sink_side
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = 39;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_octet(octet_t o);
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= o.data;
    in_ch.start_of_stream <= o.start;
    in_ch.last_byte <= o.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    octets_fed++;
    if (!quiet && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic put(logic [7:0] data, bit start, bit last);
    send_octet(octet_t'({data, start, last}));
  endtask

  // hold the input until every due result is out, then let the pipe settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tlv_sb.due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_high_tags(bit enable);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= enable;
    @(posedge clk);
    cfg_we <= 1'b0;
    tlv_sb.allow_high = enable;
    settings_used++;
    @(posedge clk);
  endtask

  function automatic void add_octet(logic [7:0] data);
    stream_q.push_back(octet_t'({data, 1'b0, 1'b0}));
  endfunction

  function automatic void add_tlv();
    int cls;
    int k;
    int num;
    int len;
    int r;
    cls = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) begin
      k = $urandom_range(1, 4);
      num = $urandom_range(k == 1 ? 31 : (1 << (7 * (k - 1))), (1 << (7 * k)) - 1);
      add_octet({cls[2:0], dtd_pkg::TAG_HIGH_ID});
      for (int j = k - 1; j >= 0; j--) add_octet({j != 0, 7'(num >> (7 * j))});
    end else begin
      add_octet({cls[2:0], 5'($urandom_range(0, 30))});
    end
    r = $urandom_range(0, 99);
    len = (r < 87) ? $urandom_range(0, 6) : (r < 97) ? $urandom_range(7, 30)
                                                     : $urandom_range(128, 160);
    if (len < 128) begin
      add_octet(8'(len));
    end else begin
      add_octet(8'h81);
      add_octet(8'(len));
    end
    repeat (len) add_octet(8'($urandom_range(0, 255)));
  endfunction

  function automatic void build_stream();
    int r;
    int k;
    int nlen;
    stream_q.delete();
    r = $urandom_range(0, 99);
    if (r < 6) begin
      // raw noise with random framing
      repeat ($urandom_range(1, 8)) add_octet(8'($urandom_range(0, 255)));
      foreach (stream_q[i]) begin
        stream_q[i].start = ($urandom_range(0, 7) == 0);
        stream_q[i].last = ($urandom_range(0, 3) == 0);
      end
    end else if (r < 12) begin
      // long-form length header, abandoned by the next start
      add_octet(8'h04);
      nlen = $urandom_range(1, 4);
      add_octet(8'(8'h80 | nlen));
      repeat (nlen) add_octet(($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom_range(0, 255)));
      repeat ($urandom_range(0, 4)) add_octet(8'($urandom_range(0, 255)));
      stream_q[0].start = 1'b1;
    end else begin
      repeat ($urandom_range(1, 2)) add_tlv();
      stream_q[0].start = ($urandom_range(0, 15) != 0);
      stream_q[stream_q.size() - 1].last = 1'b1;
      if (r >= 90) begin
        stream_q[stream_q.size() - 1].last = 1'b0;
      end else if (r >= 80) begin
        k = $urandom_range(0, stream_q.size() - 1);
        while (stream_q.size() > k + 1) void'(stream_q.pop_back());
        stream_q[k].last = 1'b1;
      end else if (r >= 70) begin
        stream_q[$urandom_range(0, stream_q.size() - 1)].data = 8'($urandom_range(0, 255));
      end
    end
  endfunction

  initial begin : run
    int phase_items;
    bit paused;
    paused = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.start_of_stream = 1'b0;
    in_ch.last_byte = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_pct = 20;
    // short tag with one content word, closed cleanly
    put(8'h02, 1, 0); put(8'h01, 0, 0); put(8'hff, 0, 1);
    // high form with all class bits, then a further TLV without a start
    put(8'hff, 1, 0); put(8'h1f, 0, 0); put(8'h00, 0, 1);
    put(8'h00, 0, 0); put(8'h00, 0, 1);
    put(8'h1f, 1, 0); put(8'h80, 0, 0);
    // tag overflow, detected at the closing word of the tag number
    put(8'h1f, 1, 0); put(8'hff, 0, 0); put(8'hff, 0, 0); put(8'hff, 0, 0);
    put(8'h05, 0, 1);
    put(8'h1f, 1, 0); put(8'h1e, 0, 1);
    put(8'h30, 1, 0); put(8'h80, 0, 0);
    put(8'h04, 1, 0); put(8'h85, 0, 0);
    put(8'h04, 1, 0); put(8'h81, 0, 0); put(8'h00, 0, 0);
    put(8'h04, 1, 0); put(8'h81, 0, 0); put(8'h7f, 0, 0);
    put(8'h04, 1, 0); put(8'h02, 0, 0); put(8'haa, 0, 1);
    // disable high tags mid-header: the tag already under way still decodes
    put(8'h1f, 1, 0);
    write_high_tags(1'b0);
    put(8'h20, 0, 0); put(8'h00, 0, 1);
    put(8'h3f, 1, 0);

    for (int p = 0; p < 4; p++) begin
      write_high_tags((p == 1) ? 1'b0 : (p == 3) ? 1'($urandom_range(0, 1)) : 1'b1);
      idle_pct = (p == 0) ? 25 : (p == 1) ? 40 : 0;
      quiet = (p == 3);
      phase_items = 0;
      while (phase_items < 215) begin
        if (p == 0 && phase_items >= 40 && hold_requests == 0) hold_requests++;
        if (p == 2 && phase_items >= 100 && !paused) begin
          drain_results();
          paused = 1'b1;
        end
        build_stream();
        foreach (stream_q[i]) send_octet(stream_q[i]);
        phase_items += stream_q.size();
      end
    end

    drain_results();
    $display("fed %0d octets across %0d high-tag settings", octets_fed, settings_used);
    $display("checked %0d headers, %0d content words, %0d decode errors",
             tlv_sb.headers, tlv_sb.bodies, tlv_sb.faults);
    if (tlv_sb.mismatches == 0 && tlv_sb.due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
